>>> sv/flash_log_ring_writer_assert.svh
// Assertion helpers shared by the log writer modules.
`ifndef FLASH_LOG_RING_WRITER_ASSERT_SVH
`define FLASH_LOG_RING_WRITER_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define FLRW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define FLRW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/flrw_pkg.sv
`default_nettype none

package flrw_pkg;

    // Field and internal widths
    localparam int CFG_W       = 20;
    localparam int PTR_W       = 21;   // pointers hold base + size
    localparam int LEN_W       = 13;
    localparam int ADDR_W      = 19;
    localparam int CNT_W       = 20;
    localparam int SRC_W       = 12;
    localparam int NRES_W      = 5;
    localparam int MAX_RESULTS = 24;

    // Request modes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_ERASE  = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;

    // Erase policies
    localparam logic [1:0] EMODE_NEVER = 2'd0;
    localparam logic [1:0] EMODE_INIT  = 2'd1;
    localparam logic [1:0] EMODE_FULL  = 2'd2;
    localparam logic [1:0] EMODE_RING  = 2'd3;

    // Flash commands
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_PROG      = 2'd1;
    localparam logic [1:0] CMD_ERASE_BLK = 2'd2;
    localparam logic [1:0] CMD_ERASE_ALL = 2'd3;

    // Register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;
    localparam logic [1:0] CFG_EMODE = 2'd2;

    // Datapath operations issued by the controller
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_FIX       = 4'd2;
    localparam logic [3:0] OP_WRAP      = 4'd3;
    localparam logic [3:0] OP_ERASE_ALL = 4'd4;
    localparam logic [3:0] OP_CALC      = 4'd5;
    localparam logic [3:0] OP_STEP      = 4'd6;
    localparam logic [3:0] OP_CHECK     = 4'd7;
    localparam logic [3:0] OP_PROG      = 4'd8;
    localparam logic [3:0] OP_BLKRP     = 4'd9;
    localparam logic [3:0] OP_BLK       = 4'd10;
    localparam logic [3:0] OP_NONE      = 4'd11;

    typedef struct packed {
        logic       accept;
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] emode;
        logic       ready;
        logic       size_zero;
        logic       wp_ge_top;
        logic       fit_fail;
        logic       loop_go;
        logic       erase_due;
        logic       nres_zero;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

>>> sv/flrw_ctrl.sv
`default_nettype none
`include "flash_log_ring_writer_assert.svh"

module flrw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  flrw_pkg::t_status i_status,
    output flrw_pkg::t_cmd   o_cmd
);
    import flrw_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DISPATCH = 4'd1;
    localparam logic [3:0] ST_LOAD     = 4'd2;
    localparam logic [3:0] ST_FIX      = 4'd3;
    localparam logic [3:0] ST_POLICY   = 4'd4;
    localparam logic [3:0] ST_ERASE    = 4'd5;
    localparam logic [3:0] ST_CALC     = 4'd6;
    localparam logic [3:0] ST_STEP     = 4'd7;
    localparam logic [3:0] ST_CHECK    = 4'd8;
    localparam logic [3:0] ST_PROG     = 4'd9;
    localparam logic [3:0] ST_BLKRP    = 4'd10;
    localparam logic [3:0] ST_BLK      = 4'd11;
    localparam logic [3:0] ST_NONE     = 4'd12;

    logic [3:0] r_state, n_state;
    logic       emit_op;

    // Next state and datapath command
    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.op     = OP_NOP;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (i_status.mode)
                    MODE_APPEND: n_state = (!i_status.ready || i_status.size_zero) ?
                                           ST_NONE : ST_FIX;
                    MODE_ERASE:  n_state = ST_ERASE;
                    MODE_LOAD:   n_state = (i_status.emode == EMODE_INIT) ?
                                           ST_ERASE : ST_LOAD;
                    default:     n_state = ST_NONE;
                endcase
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = ST_NONE;
            end
            ST_FIX: begin
                o_cmd.op = OP_FIX;
                n_state  = ST_POLICY;
            end
            ST_POLICY: begin
                unique case (i_status.emode)
                    EMODE_NEVER, EMODE_INIT: n_state = i_status.wp_ge_top ?
                                                       ST_NONE : ST_CALC;
                    EMODE_FULL: n_state = i_status.fit_fail ? ST_ERASE : ST_CALC;
                    EMODE_RING: begin
                        o_cmd.op = OP_WRAP;
                        n_state  = ST_CALC;
                    end
                endcase
            end
            ST_ERASE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_ERASE_ALL;
                    n_state  = (i_status.mode == MODE_APPEND) ? ST_CALC : ST_IDLE;
                end
            end
            ST_CALC: begin
                if (i_status.loop_go) begin
                    o_cmd.op = OP_CALC;
                    n_state  = ST_STEP;
                end else begin
                    n_state = i_status.nres_zero ? ST_NONE : ST_IDLE;
                end
            end
            ST_STEP: begin
                o_cmd.op = OP_STEP;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.op = OP_CHECK;
                n_state  = ST_PROG;
            end
            ST_PROG: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_PROG;
                    n_state  = i_status.erase_due ? ST_BLKRP : ST_CALC;
                end
            end
            ST_BLKRP: begin
                o_cmd.op = OP_BLKRP;
                n_state  = ST_BLK;
            end
            ST_BLK: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_BLK;
                    n_state  = ST_CALC;
                end
            end
            ST_NONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_NONE;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign emit_op = (o_cmd.op == OP_PROG) || (o_cmd.op == OP_BLK) ||
                     (o_cmd.op == OP_NONE) || (o_cmd.op == OP_ERASE_ALL);

    `FLRW_ASSERT_IMP(a_emit_needs_room, i_clk, i_rst_n, emit_op, i_status.out_free, "result issued while output register busy")
    `FLRW_ASSERT_IMP(a_idle_no_work, i_clk, i_rst_n, o_in_ready, o_cmd.op == OP_NOP, "datapath work while taking an item")
    `FLRW_ASSERT_NXT(a_none_ends_item, i_clk, i_rst_n, o_cmd.op == OP_NONE, o_in_ready, "no-command result did not end the item")

endmodule

`default_nettype wire

>>> sv/flrw_datapath.sv
`default_nettype none
`include "flash_log_ring_writer_assert.svh"

module flrw_datapath #(
    parameter int PAGE_BYTES  = 256,
    parameter int BLOCK_BYTES = 4096,
    parameter int FLASH_BYTES = 524288,
    parameter int MAX_APPEND  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  flrw_pkg::t_cmd                i_cmd,
    output flrw_pkg::t_status             o_status,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [flrw_pkg::CFG_W-1:0]    i_cfg_data,
    // request fields
    input  logic [1:0]                    i_mode,
    input  logic [flrw_pkg::LEN_W-1:0]    i_length,
    input  logic [flrw_pkg::CFG_W-1:0]    i_start_value,
    input  logic [flrw_pkg::CFG_W-1:0]    i_end_value,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_command,
    output logic [flrw_pkg::ADDR_W-1:0]   o_address,
    output logic [flrw_pkg::CNT_W-1:0]    o_count,
    output logic [flrw_pkg::SRC_W-1:0]    o_source_offset,
    output logic                          o_last,
    output logic [flrw_pkg::CNT_W-1:0]    o_bytes_used
);
    import flrw_pkg::*;

    localparam logic [PTR_W-1:0]   PAGE_MASK = PTR_W'(PAGE_BYTES - 1);
    localparam logic [PTR_W-1:0]   BLK_MASK  = PTR_W'(BLOCK_BYTES - 1);
    localparam logic [PTR_W:0]     BLOCK_P   = (PTR_W + 1)'(BLOCK_BYTES);
    localparam logic [LEN_W-1:0]   PAGE_L    = LEN_W'(PAGE_BYTES);
    localparam logic [LEN_W-1:0]   MAX_L     = LEN_W'(MAX_APPEND);
    localparam logic [ADDR_W-1:0]  AMASK     = ADDR_W'(FLASH_BYTES - 1);
    localparam logic [CNT_W-1:0]   BLOCK_CNT = CNT_W'(BLOCK_BYTES);
    localparam logic [NRES_W-1:0]  LOOP_LIM  = NRES_W'(MAX_RESULTS - 2);
    localparam logic [NRES_W-1:0]  MORE_LIM  = NRES_W'(MAX_RESULTS - 3);
    localparam logic [NRES_W-1:0]  NRES_TOP  = NRES_W'(MAX_RESULTS);

    // configuration and pointer state
    logic [CFG_W-1:0]  r_base, r_size;
    logic [1:0]        r_emode;
    logic [PTR_W-1:0]  r_top;
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic              r_ready;
    // per-item working registers
    logic [1:0]        r_mode;
    logic [CFG_W-1:0]  r_start, r_end;
    logic [LEN_W-1:0]  r_rem, r_src, r_chunk;
    logic [NRES_W-1:0] r_nres;
    logic [PTR_W-1:0]  r_at, r_nwp, r_pad;
    logic              r_blk_edge;
    // output register
    logic              r_o_valid;
    logic [1:0]        r_o_cmd;
    logic [ADDR_W-1:0] r_o_addr;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [SRC_W-1:0]  r_o_src;
    logic              r_o_last;
    logic [CNT_W-1:0]  r_o_used;

    logic [PTR_W-1:0]  base_p, size_p;
    logic              ring, emit, out_free;
    logic [LEN_W-1:0]  page_room, c1, chunk;
    logic [PTR_W-1:0]  top_room, step_sum, nwp;
    logic [PTR_W:0]    pad_sum, rp_sum;
    logic [PTR_W-1:0]  pad, rp_next;
    logic              erase_due, more_prog, more_blk, erase_last;

    // Clamp a write pointer into [base, top]
    function automatic logic [PTR_W-1:0] fix_w(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] lo,
                                               input logic [PTR_W-1:0] hi);
        return (p < lo || p > hi) ? lo : p;
    endfunction

    // Clamp a read pointer into [base, top)
    function automatic logic [PTR_W-1:0] fix_r(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] lo,
                                               input logic [PTR_W-1:0] hi);
        return (p < lo || p >= hi) ? lo : p;
    endfunction

    // Live bytes between read and write pointer, modulo 2^20
    function automatic logic [CNT_W-1:0] used_of(input logic [PTR_W-1:0] wp,
                                                 input logic [PTR_W-1:0] rp,
                                                 input logic [PTR_W-1:0] sz,
                                                 input logic             rdy);
        logic [PTR_W-1:0] d;
        d = (rp > wp) ? (sz + wp - rp) : (wp - rp);
        return rdy ? d[CNT_W-1:0] : '0;
    endfunction

    assign base_p   = PTR_W'(r_base);
    assign size_p   = PTR_W'(r_size);
    assign ring     = (r_emode == EMODE_RING);
    assign out_free = !r_o_valid || i_out_ready;
    assign emit     = (i_cmd.op == OP_PROG) || (i_cmd.op == OP_BLK) ||
                      (i_cmd.op == OP_NONE) || (i_cmd.op == OP_ERASE_ALL);

    // chunk size: stop at page end, remaining data and region end
    assign page_room = PAGE_L - LEN_W'(r_wp & PAGE_MASK);
    assign top_room  = r_top - r_wp;
    assign c1        = (page_room < r_rem) ? page_room : r_rem;
    assign chunk     = (PTR_W'(c1) > top_room) ? LEN_W'(top_room) : c1;

    // write pointer after the chunk, ring wrap
    assign step_sum = r_at + PTR_W'(r_chunk);
    assign nwp      = (ring && step_sum >= r_top) ? base_p : step_sum;

    // block ahead of the write pointer
    assign pad_sum = {1'b0, r_nwp} + BLOCK_P;
    assign pad     = (pad_sum >= {1'b0, r_top}) ? base_p : pad_sum[PTR_W-1:0];
    assign rp_sum  = {1'b0, r_rp} + BLOCK_P;
    assign rp_next = (rp_sum >= {1'b0, r_top}) ? base_p : rp_sum[PTR_W-1:0];

    // what follows the current result
    assign erase_due  = ring && r_blk_edge && (r_pad == r_rp);
    assign more_prog  = (r_rem != r_chunk) && (r_nres <= MORE_LIM) && (r_nwp < r_top);
    assign more_blk   = (r_rem != '0) && (r_nres <= MORE_LIM) && (r_wp < r_top);
    assign erase_last = (r_mode != MODE_APPEND) || (r_rem == '0);

    // status toward the controller
    always_comb begin
        o_status.mode      = r_mode;
        o_status.emode     = r_emode;
        o_status.ready     = r_ready;
        o_status.size_zero = (r_size == '0);
        o_status.wp_ge_top = (r_wp >= r_top);
        o_status.fit_fail  = (PTR_W'(r_rem) > size_p) ||
                             (({1'b0, r_wp} + (PTR_W + 1)'(r_rem)) > {1'b0, r_top});
        o_status.loop_go   = (r_rem != '0) && (r_nres <= LOOP_LIM) && (r_wp < r_top);
        o_status.erase_due = erase_due;
        o_status.nres_zero = (r_nres == '0);
        o_status.out_free  = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_size    <= CFG_W'(524288);
            r_emode   <= EMODE_RING;
            r_top     <= PTR_W'(524288);
            r_wp      <= '0;
            r_rp      <= '0;
            r_ready   <= 1'b0;
            r_nres    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BASE:  r_base  <= i_cfg_data;
                    CFG_SIZE:  r_size  <= i_cfg_data;
                    CFG_EMODE: r_emode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            r_top <= base_p + size_p;

            // take a new item
            if (i_cmd.accept) begin
                r_mode  <= i_mode;
                r_rem   <= (i_length > MAX_L) ? MAX_L : i_length;
                r_src   <= '0;
                r_nres  <= '0;
                r_start <= i_start_value;
                r_end   <= i_end_value;
            end

            // output valid
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_wp    <= fix_w(PTR_W'(r_end), base_p, r_top);
                    r_rp    <= fix_r(PTR_W'(r_start), base_p, r_top);
                    r_ready <= 1'b1;
                end
                OP_FIX: begin
                    r_wp <= fix_w(r_wp, base_p, r_top);
                    r_rp <= fix_r(r_rp, base_p, r_top);
                end
                OP_WRAP: begin
                    if (r_wp >= r_top) begin
                        r_wp <= base_p;
                    end
                end
                OP_ERASE_ALL: begin
                    r_wp     <= base_p;
                    r_rp     <= base_p;
                    r_ready  <= 1'b1;
                    r_nres   <= r_nres + 1'b1;
                    r_o_cmd  <= CMD_ERASE_ALL;
                    r_o_addr <= ADDR_W'(base_p) & AMASK;
                    r_o_cnt  <= r_size;
                    r_o_src  <= '0;
                    r_o_last <= erase_last;
                    r_o_used <= '0;
                end
                OP_CALC: begin
                    r_at    <= r_wp;
                    r_chunk <= chunk;
                end
                OP_STEP: begin
                    r_nwp <= nwp;
                end
                OP_CHECK: begin
                    r_pad      <= pad;
                    r_blk_edge <= ((r_nwp - base_p) & BLK_MASK) == '0;
                end
                OP_PROG: begin
                    r_wp     <= r_nwp;
                    r_rem    <= r_rem - r_chunk;
                    r_src    <= r_src + r_chunk;
                    r_nres   <= r_nres + 1'b1;
                    r_o_cmd  <= CMD_PROG;
                    r_o_addr <= ADDR_W'(r_at) & AMASK;
                    r_o_cnt  <= CNT_W'(r_chunk);
                    r_o_src  <= r_src[SRC_W-1:0];
                    r_o_last <= !(erase_due || more_prog);
                    r_o_used <= used_of(r_nwp, r_rp, size_p, r_ready);
                end
                OP_BLKRP: begin
                    r_rp <= rp_next;
                end
                OP_BLK: begin
                    r_nres   <= r_nres + 1'b1;
                    r_o_cmd  <= CMD_ERASE_BLK;
                    r_o_addr <= ADDR_W'(r_pad) & AMASK;
                    r_o_cnt  <= BLOCK_CNT;
                    r_o_src  <= '0;
                    r_o_last <= !more_blk;
                    r_o_used <= used_of(r_wp, r_rp, size_p, r_ready);
                end
                OP_NONE: begin
                    r_o_cmd  <= CMD_NONE;
                    r_o_addr <= '0;
                    r_o_cnt  <= '0;
                    r_o_src  <= '0;
                    r_o_last <= 1'b1;
                    r_o_used <= used_of(r_wp, r_rp, size_p, r_ready);
                end
                default: ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_o_valid;
    assign o_command       = r_o_cmd;
    assign o_address       = r_o_addr;
    assign o_count         = r_o_cnt;
    assign o_source_offset = r_o_src;
    assign o_last          = r_o_last;
    assign o_bytes_used    = r_o_used;

    `FLRW_ASSERT_IMP(a_chunk_nonzero, i_clk, i_rst_n, i_cmd.op == OP_PROG, (r_chunk != '0) && (r_chunk <= PAGE_L), "program chunk empty or above a page")
    `FLRW_ASSERT_IMP(a_chunk_in_page, i_clk, i_rst_n, i_cmd.op == OP_PROG, ((r_at & PAGE_MASK) + PTR_W'(r_chunk)) <= PTR_W'(PAGE_BYTES), "program chunk crosses a page")
    `FLRW_ASSERT_IMP(a_blk_ring_only, i_clk, i_rst_n, i_cmd.op == OP_BLK, r_emode == EMODE_RING, "block erase outside ring mode")
    `FLRW_ASSERT_IMP(a_result_cap, i_clk, i_rst_n, 1'b1, r_nres <= NRES_TOP, "too many results for one item")
    `FLRW_ASSERT_NXT(a_prog_lands, i_clk, i_rst_n, i_cmd.op == OP_PROG, r_o_valid && (r_o_cmd == CMD_PROG), "program result not presented")

endmodule

`default_nettype wire

>>> sv/flash_log_ring_writer.sv
// After accept the dispatch state leads to an erase or a no-command result, to a pointer
// load and then a no-command result (a store erase instead in erase-on-init mode), or for an
// append to the pointer fix, the erase policy (with a store erase when full) and per chunk the
// calc, step, check and program states, then a block erase where due. Output stalls hold the block longer.
// Reset (i_rst_n low at a clock edge): pointers to zero, not ready, registers to
// base 0, size 524288, ring mode; no clearing pass.
`default_nettype none

module flash_log_ring_writer #(
    parameter int PAGE_BYTES  = 256,
    parameter int BLOCK_BYTES = 4096,
    parameter int FLASH_BYTES = 524288,
    parameter int MAX_APPEND  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [flrw_pkg::CFG_W-1:0]    i_cfg_data,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [flrw_pkg::LEN_W-1:0]    i_length,
    input  logic [flrw_pkg::CFG_W-1:0]    i_start_value,
    input  logic [flrw_pkg::CFG_W-1:0]    i_end_value,
    // command channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_command,
    output logic [flrw_pkg::ADDR_W-1:0]   o_address,
    output logic [flrw_pkg::CNT_W-1:0]    o_count,
    output logic [flrw_pkg::SRC_W-1:0]    o_source_offset,
    output logic                          o_last,
    output logic [flrw_pkg::CNT_W-1:0]    o_bytes_used
);
    import flrw_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    flrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // pointers, chunking and result register
    flrw_datapath #(
        .PAGE_BYTES  (PAGE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .FLASH_BYTES (FLASH_BYTES),
        .MAX_APPEND  (MAX_APPEND)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_length        (i_length),
        .i_start_value   (i_start_value),
        .i_end_value     (i_end_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_command       (o_command),
        .o_address       (o_address),
        .o_count         (o_count),
        .o_source_offset (o_source_offset),
        .o_last          (o_last),
        .o_bytes_used    (o_bytes_used)
    );

endmodule

`default_nettype wire

>>> dv/flrw_cmd_checker.sv
`timescale 1ns / 1ps

// Watches the register, request and command channels of the log writer,
// predicts the flash commands of every accepted request and compares them in order.
module flrw_cmd_checker #(
    parameter int PAGE_BYTES  = 256,
    parameter int BLOCK_BYTES = 4096,
    parameter int FLASH_BYTES = 524288,
    parameter int MAX_APPEND  = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // register writes
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [flrw_pkg::CFG_W-1:0]    i_cfg_data,
    // requests
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_mode,
    input  logic [flrw_pkg::LEN_W-1:0]    i_length,
    input  logic [flrw_pkg::CFG_W-1:0]    i_start_value,
    input  logic [flrw_pkg::CFG_W-1:0]    i_end_value,
    // flash commands
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [1:0]                    i_command,
    input  logic [flrw_pkg::ADDR_W-1:0]   i_address,
    input  logic [flrw_pkg::CNT_W-1:0]    i_count,
    input  logic [flrw_pkg::SRC_W-1:0]    i_source_offset,
    input  logic                          i_last,
    input  logic [flrw_pkg::CNT_W-1:0]    i_bytes_used,
    // status to the testbench top
    output int                            o_mismatches,
    output int                            o_outstanding
);

    import flrw_pkg::*;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  count;
        logic [SRC_W-1:0]  src_offset;
        logic              last;
        logic [CNT_W-1:0]  bytes_used;
    } t_flash_cmd;

    // Predicted commands, oldest first
    t_flash_cmd expected_cmds[$];
    // Commands of the request being predicted
    t_flash_cmd step_cmds[MAX_RESULTS];
    int         step_n;

    // Shadow registers and pointers, kept wide like absolute addresses
    logic [31:0] reg_base;
    logic [31:0] reg_size;
    logic [1:0]  reg_emode;
    logic [31:0] wr_ptr;
    logic [31:0] rd_ptr;
    logic        store_ready;

    int          err_count = 0;
    t_flash_cmd  seen_cmd;
    t_flash_cmd  want_cmd;

    // Live bytes between read and write pointer
    function automatic logic [CNT_W-1:0] live_bytes();
        logic [31:0] diff;
        if (!store_ready) return '0;
        if (rd_ptr > wr_ptr) diff = reg_size - (rd_ptr - wr_ptr);
        else diff = wr_ptr - rd_ptr;
        return diff[CNT_W-1:0];
    endfunction

    // Record one command; at most MAX_RESULTS per request
    task automatic push_cmd(input logic [1:0] cmd, input logic [31:0] addr,
                            input logic [31:0] cnt, input logic [31:0] src);
        t_flash_cmd  c;
        logic [31:0] a;
        if (step_n >= MAX_RESULTS) return;
        a = addr % FLASH_BYTES;
        c.command    = cmd;
        c.address    = a[ADDR_W-1:0];
        c.count      = cnt[CNT_W-1:0];
        c.src_offset = src[SRC_W-1:0];
        c.last       = 1'b0;
        c.bytes_used = live_bytes();
        step_cmds[step_n] = c;
        step_n++;
    endtask

    task automatic wipe_store();
        wr_ptr      = reg_base;
        rd_ptr      = reg_base;
        store_ready = 1'b1;
        push_cmd(CMD_ERASE_ALL, reg_base, reg_size, 0);
    endtask

    // Out-of-region pointers fall back to the base
    task automatic clamp_ptrs(input logic [31:0] top);
        if (wr_ptr < reg_base || wr_ptr > top) wr_ptr = reg_base;
        if (rd_ptr < reg_base || rd_ptr >= top) rd_ptr = reg_base;
    endtask

    // Split an append into page chunks, with ring block erases
    task automatic append_bytes(input logic [31:0] req_len);
        logic [31:0] len;
        logic [31:0] top;
        logic [31:0] rem;
        logic [31:0] src;
        logic [31:0] at;
        logic [31:0] chunk;
        logic [31:0] pad;
        len = req_len;
        if (!store_ready || reg_size == 0) return;
        if (len > MAX_APPEND) len = MAX_APPEND;
        top = reg_base + reg_size;
        clamp_ptrs(top);

        if (reg_emode == EMODE_NEVER || reg_emode == EMODE_INIT) begin
            if (wr_ptr >= top) return;
        end else if (reg_emode == EMODE_FULL) begin
            if (len > reg_size || wr_ptr + len > top) wipe_store();
        end else if (wr_ptr >= top) begin
            wr_ptr = reg_base;
        end

        rem = len;
        src = 0;
        while (rem != 0) begin
            at = wr_ptr;
            if (step_n > MAX_RESULTS - 2) break;
            if (at >= top) break;
            chunk = PAGE_BYTES - (at % PAGE_BYTES);
            if (chunk > rem) chunk = rem;
            if (chunk > top - at) chunk = top - at;
            wr_ptr = at + chunk;
            if (reg_emode == EMODE_RING && wr_ptr >= top) wr_ptr = reg_base;
            push_cmd(CMD_PROG, at, chunk, src);
            src = src + chunk;
            rem = rem - chunk;
            // ring: erase the next block if it holds the oldest data
            if (reg_emode == EMODE_RING && ((wr_ptr - reg_base) % BLOCK_BYTES) == 0) begin
                pad = wr_ptr + BLOCK_BYTES;
                if (pad >= top) pad = reg_base;
                if (pad == rd_ptr) begin
                    rd_ptr = rd_ptr + BLOCK_BYTES;
                    if (rd_ptr >= top) rd_ptr = reg_base;
                    push_cmd(CMD_ERASE_BLK, pad, BLOCK_BYTES, 0);
                end
            end
        end
    endtask

    task automatic load_ptrs(input logic [31:0] oldest_at, input logic [31:0] free_at);
        if (reg_emode == EMODE_INIT) begin
            wipe_store();
            return;
        end
        wr_ptr = free_at;
        rd_ptr = oldest_at;
        clamp_ptrs(reg_base + reg_size);
        store_ready = 1'b1;
    endtask

    // Commands caused by one request, queued in order
    task automatic predict_commands(input logic [1:0] mode, input logic [LEN_W-1:0] len,
                                    input logic [CFG_W-1:0] oldest_at,
                                    input logic [CFG_W-1:0] free_at);
        t_flash_cmd c;
        step_n = 0;
        case (mode)
            MODE_APPEND: append_bytes({19'd0, len});
            MODE_ERASE:  wipe_store();
            MODE_LOAD:   load_ptrs({12'd0, oldest_at}, {12'd0, free_at});
            default: ;
        endcase
        if (step_n == 0) push_cmd(CMD_NONE, 0, 0, 0);
        c = step_cmds[step_n - 1];
        c.last = 1'b1;
        step_cmds[step_n - 1] = c;
        for (int k = 0; k < step_n; k++) expected_cmds.push_back(step_cmds[k]);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        err_count++;
        if (err_count <= 10)
            $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_base    = '0;
            reg_size    = 32'h80000;
            reg_emode   = EMODE_RING;
            wr_ptr      = '0;
            rd_ptr      = '0;
            store_ready = 1'b0;
            expected_cmds.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:  reg_base = {12'd0, i_cfg_data};
                    CFG_SIZE:  reg_size = {12'd0, i_cfg_data};
                    CFG_EMODE: reg_emode = i_cfg_data[1:0];
                    default: ;
                endcase
            end

            // accepted request
            if (i_in_valid && i_in_ready)
                predict_commands(i_mode, i_length, i_start_value, i_end_value);

            // accepted command against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                seen_cmd.command    = i_command;
                seen_cmd.address    = i_address;
                seen_cmd.count      = i_count;
                seen_cmd.src_offset = i_source_offset;
                seen_cmd.last       = i_last;
                seen_cmd.bytes_used = i_bytes_used;
                if (expected_cmds.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t ns: unexpected command %0d at 0x%0h, count %0d",
                                 $time, i_command, i_address, i_count);
                end else begin
                    want_cmd = expected_cmds.pop_front();
                    if (seen_cmd.command != want_cmd.command)
                        flag_mismatch("command", want_cmd.command, seen_cmd.command);
                    if (seen_cmd.address != want_cmd.address)
                        flag_mismatch("address", want_cmd.address, seen_cmd.address);
                    if (seen_cmd.count != want_cmd.count)
                        flag_mismatch("count", want_cmd.count, seen_cmd.count);
                    if (seen_cmd.src_offset != want_cmd.src_offset)
                        flag_mismatch("source_offset", want_cmd.src_offset,
                                      seen_cmd.src_offset);
                    if (seen_cmd.last != want_cmd.last)
                        flag_mismatch("last", want_cmd.last, seen_cmd.last);
                    if (seen_cmd.bytes_used != want_cmd.bytes_used)
                        flag_mismatch("bytes_used", want_cmd.bytes_used,
                                      seen_cmd.bytes_used);
                end
            end
        end
        o_outstanding = expected_cmds.size();
        o_mismatches  = err_count;
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import flrw_pkg::*;

    localparam int PAGE_BYTES   = 256;
    localparam int BLOCK_BYTES  = 4096;
    localparam int FLASH_BYTES  = 524288;
    localparam int MAX_APPEND   = 4096;
    localparam int TOTAL_ITEMS  = 460;
    localparam int IDLE_CYCLES  = 20;    // block finishing after its last command
    localparam int END_CYCLES   = 200;

    // index past the last register, ignored by the block
    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    // request mode with no meaning, answered by the block with a no-command result
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index    = '0;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [1:0]          in_mode      = '0;
    logic [LEN_W-1:0]    in_length    = '0;
    logic [CFG_W-1:0]    in_start     = '0;
    logic [CFG_W-1:0]    in_end       = '0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic [1:0]          out_command;
    logic [ADDR_W-1:0]   out_address;
    logic [CNT_W-1:0]    out_count;
    logic [SRC_W-1:0]    out_source_offset;
    logic                out_last;
    logic [CNT_W-1:0]    out_bytes_used;

    int                  mismatches;
    int                  outstanding;

    // current region, for well-formed pointer loads
    logic [CFG_W-1:0]    cur_base;
    logic [CFG_W-1:0]    cur_size;
    bit                  steady       = 1'b0;   // no request gaps in this phase
    int                  reqs_sent    = 0;
    int                  rdy_hold     = 0;

    always #5 clk = ~clk;

    flash_log_ring_writer #(
        .PAGE_BYTES  (PAGE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .FLASH_BYTES (FLASH_BYTES),
        .MAX_APPEND  (MAX_APPEND)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_length        (in_length),
        .i_start_value   (in_start),
        .i_end_value     (in_end),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_command       (out_command),
        .o_address       (out_address),
        .o_count         (out_count),
        .o_source_offset (out_source_offset),
        .o_last          (out_last),
        .o_bytes_used    (out_bytes_used)
    );

    flrw_cmd_checker #(
        .PAGE_BYTES  (PAGE_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES),
        .FLASH_BYTES (FLASH_BYTES),
        .MAX_APPEND  (MAX_APPEND)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (in_mode),
        .i_length        (in_length),
        .i_start_value   (in_start),
        .i_end_value     (in_end),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_command       (out_command),
        .i_address       (out_address),
        .i_count         (out_count),
        .i_source_offset (out_source_offset),
        .i_last          (out_last),
        .i_bytes_used    (out_bytes_used),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // Gap lengths: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 98) return $urandom_range(12, 4);
        return $urandom_range(50, 20);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(99, 0);
        if (r < 85) return $urandom_range(2, 0);
        if (r < 97) return $urandom_range(9, 3);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(99, 0);
        if (r < 10) return LEN_W'($urandom_range(16, 1));
        if (r < 50) return LEN_W'($urandom_range(256, 17));
        if (r < 72) return LEN_W'($urandom_range(4096, 257));
        if (r < 84) begin
            case ($urandom_range(3, 0))
                0: return 13'd256;
                1: return 13'd4095;
                2: return 13'd4096;
                default: return 13'd512;
            endcase
        end
        if (r < 94) return LEN_W'($urandom_range(8191, 4097));
        return '0;
    endfunction

    // Command side back-pressure: ready runs broken by stalls
    always @(negedge clk) begin
        if (rdy_hold > 0) begin
            rdy_hold--;
        end else if (out_ready) begin
            out_ready <= 1'b0;
            rdy_hold = stall_len();
        end else begin
            out_ready <= 1'b1;
            rdy_hold = ($urandom_range(4, 0) == 0) ? $urandom_range(200, 40)
                                                   : $urandom_range(15, 0);
        end
    end

    // One request item; called at a falling edge, returns at one
    task automatic send_req(input logic [1:0] mode, input logic [LEN_W-1:0] len,
                            input logic [CFG_W-1:0] oldest_at,
                            input logic [CFG_W-1:0] free_at);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_mode   <= mode;
        in_length <= len;
        in_start  <= oldest_at;
        in_end    <= free_at;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        reqs_sent++;
        @(negedge clk);
    endtask

    // unused fields carry random values
    task automatic req_append(input logic [LEN_W-1:0] len);
        send_req(MODE_APPEND, len, CFG_W'($urandom), CFG_W'($urandom));
    endtask

    task automatic req_erase();
        send_req(MODE_ERASE, LEN_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    endtask

    task automatic req_load(input logic [CFG_W-1:0] oldest_at,
                            input logic [CFG_W-1:0] free_at);
        send_req(MODE_LOAD, LEN_W'($urandom), oldest_at, free_at);
    endtask

    task automatic req_noise();
        send_req(MODE_UNUSED, LEN_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    endtask

    // Load with pointers inside the current region
    task automatic req_load_in_region();
        logic [CFG_W-1:0] sa;
        logic [CFG_W-1:0] ea;
        if (cur_size == 0) begin
            sa = cur_base;
            ea = cur_base;
        end else begin
            if (cur_size >= BLOCK_BYTES)
                sa = cur_base + CFG_W'(BLOCK_BYTES *
                                       $urandom_range(cur_size / BLOCK_BYTES - 1, 0));
            else
                sa = cur_base + CFG_W'($urandom_range(cur_size - 1, 0));
            ea = cur_base + CFG_W'($urandom_range(cur_size, 0));
        end
        req_load(sa, ea);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data,
                             input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        if (!hold) cfg_valid <= 1'b0;
    endtask

    task automatic set_region(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] size,
                              input logic [1:0] emode, input bit spare);
        cur_base  = base;
        cur_size  = size;
        cfg_write(CFG_BASE, base, 1'b1);
        cfg_write(CFG_SIZE, size, 1'b1);
        cfg_write(CFG_EMODE, {18'd0, emode}, spare);
        if (spare) cfg_write(CFG_UNUSED, CFG_W'($urandom), 1'b0);
    endtask

    // Wait until every predicted command has come and the block is idle
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (IDLE_CYCLES) @(negedge clk);
    endtask

    // Run limit
    initial begin
        #30000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int r;
        int n;
        int erase_pct;
        logic [CFG_W-1:0] base;
        logic [CFG_W-1:0] size;
        logic [1:0]       emode;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        cur_base  = '0;
        cur_size  = 20'h80000;

        // reset defaults: not ready, unused mode, then max and oversize appends
        req_append(13'd10);
        req_noise();
        req_erase();
        req_append(13'd0);
        req_append(13'd4096);
        req_append(13'h1FFF);
        req_append(13'd1);
        req_append(13'd300);

        // two-block ring: block erases and wrap; pointers out of region
        settle();
        set_region(20'h01000, 20'h02000, EMODE_RING, 1'b0);
        req_load(20'hFFFFF, 20'hFFFFF);
        req_append(13'd4096);
        req_append(13'd4096);
        req_load(20'h03000, 20'h03000);
        req_append(13'd100);

        // erase when full, region crossing the end of flash
        settle();
        set_region(20'h7F000, 20'h02000, EMODE_FULL, 1'b0);
        req_erase();
        req_append(13'd4000);
        req_append(13'd4000);
        req_append(13'd4097);

        // highest base, append larger than the region
        settle();
        set_region(20'h80000, 20'h00800, EMODE_FULL, 1'b0);
        req_load(20'h80000, 20'h80400);
        req_append(13'd4096);

        // never erase: fill, partial chunk at the end, then dropped
        settle();
        set_region(20'h00000, 20'h01000, EMODE_NEVER, 1'b0);
        req_erase();
        req_append(13'd4000);
        req_append(13'd200);
        req_append(13'd5);

        // erase on init with an empty region
        settle();
        set_region(20'h02000, 20'h00000, EMODE_INIT, 1'b1);
        req_load(20'h02000, 20'h02000);
        req_append(13'd50);

        // random phases, each with its own region
        while (reqs_sent < TOTAL_ITEMS) begin
            settle();
            r = $urandom_range(99, 0);
            emode = (r < 40) ? EMODE_RING : (r < 65) ? EMODE_FULL :
                    (r < 85) ? EMODE_NEVER : EMODE_INIT;
            r = $urandom_range(99, 0);
            if (r < 70)      size = CFG_W'(BLOCK_BYTES * $urandom_range(4, 1));
            else if (r < 85) size = CFG_W'(BLOCK_BYTES * $urandom_range(32, 5));
            else if (r < 92) size = CFG_W'($urandom_range(32768, 1));
            else if (r < 97) size = 20'h80000;
            else             size = '0;
            r = $urandom_range(99, 0);
            if (r < 70)      base = CFG_W'(BLOCK_BYTES * $urandom_range(128, 0));
            else if (r < 85) base = CFG_W'($urandom_range(524288, 0));
            else             base = 20'h80000 - CFG_W'(BLOCK_BYTES * $urandom_range(2, 0));
            set_region(base, size, emode, $urandom_range(7, 0) == 0);
            steady = ($urandom_range(3, 0) == 0);

            // start from a fresh or scanned region
            if (emode == EMODE_INIT || $urandom_range(1, 0) == 0) req_erase();
            else req_load_in_region();

            n = (size == 0) ? 3 : $urandom_range(50, 20);
            erase_pct = (emode == EMODE_NEVER || emode == EMODE_INIT) ? 10 : 4;
            for (int k = 0; k < n && reqs_sent < TOTAL_ITEMS; k++) begin
                r = $urandom_range(99, 0);
                if (r < 3) req_noise();
                else if (r < 3 + erase_pct) req_erase();
                else if (r < 11 + erase_pct) begin
                    if ($urandom_range(9, 0) < 7) req_load_in_region();
                    else req_load(CFG_W'($urandom), CFG_W'($urandom));
                end else req_append(pick_length());
            end
        end

        settle();
        repeat (END_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
